// ===== rtl/pulse_freq_duty_mode_filter_defines.svh =====
// ---------------------------------------------------------------------------
// pulse_freq_duty_mode_filter assertion macros
// Immediate-consequence and next-cycle checks on clk, disabled in reset.
// ---------------------------------------------------------------------------
`ifndef PULSE_FREQ_DUTY_MODE_FILTER_DEFINES_SVH
`define PULSE_FREQ_DUTY_MODE_FILTER_DEFINES_SVH

`ifndef NO_ASSERTIONS
`define PFDM_ASSERT_IMP(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);
`define PFDM_ASSERT_NXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);
`else
`define PFDM_ASSERT_IMP(lbl, ante, cons, msg)
`define PFDM_ASSERT_NXT(lbl, ante, cons, msg)
`endif

`endif

// ===== rtl/pfdm_pkg.sv =====
// ---------------------------------------------------------------------------
// pfdm_pkg
// Shared constants, payload structs, control structs and state types.
// ---------------------------------------------------------------------------
`default_nettype none

package pfdm_pkg;

    localparam int TABLE_SLOTS = 10;
    localparam int SLOT_IDX_W  = (TABLE_SLOTS > 1) ? $clog2(TABLE_SLOTS) : 1;
    localparam int TICK_HZ     = 1000000;

    localparam int DIV_W      = 32;
    localparam int DIVISOR_W  = 16;
    localparam int DIV_CNT_W  = $clog2(DIV_W);

    localparam logic [15:0] MIN_PERIOD  = 16'd16;
    localparam logic [15:0] DUTY_SCALE  = 16'd25600;
    localparam logic [15:0] WIDTH_SCALE = 16'd10000;
    localparam logic [19:0] WIDTH_MAX   = 20'd1000000;
    localparam logic [15:0] COUNT_MAX   = 16'hFFFF;

    localparam int CFG_IDX_W = 3;
    localparam logic [CFG_IDX_W-1:0] REG_FREQ_LOW       = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_FREQ_HIGH      = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_DUTY_LOW       = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_DUTY_HIGH      = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_CLEAR_INTERVAL = 3'd4;

    typedef struct packed {
        logic [15:0] start_rise;
        logic [15:0] fall_stamp;
        logic [15:0] end_rise;
    } meas_t;

    typedef struct packed {
        logic [15:0] mode_freq;
        logic [14:0] duty_q8;
        logic [19:0] high_time_us;
        logic        in_range;
        logic        bad_period;
    } result_t;

    typedef struct packed {
        logic                 start;
        logic [DIV_W-1:0]     dividend;
        logic [DIVISOR_W-1:0] divisor;
    } div_cmd_t;

    typedef struct packed {
        logic             done;
        logic [DIV_W-1:0] quotient;
    } div_stat_t;

    typedef struct packed {
        logic        clear;
        logic        insert;
        logic [15:0] freq;
    } tbl_cmd_t;

    typedef struct packed {
        logic        done;
        logic [15:0] mode_freq;
    } tbl_stat_t;

    typedef enum logic [2:0] {
        TB_IDLE,
        TB_FIND,
        TB_EVICT,
        TB_MODE,
        TB_DONE
    } tbl_state_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_PREP,
        ST_DUTY,
        ST_FREQ,
        ST_TABLE,
        ST_WIDTH,
        ST_OUT
    } pfdm_state_t;

endpackage

`default_nettype wire

// ===== rtl/pulse_freq_duty_mode_filter.sv =====
// ---------------------------------------------------------------------------
// pulse_freq_duty_mode_filter
// A zero period skips the divides. Otherwise up to three divides (duty,
// frequency, high time) run in turn on the shared 32-step divider, with a
// table insert and mode scan, evicting a slot when none fits, before the last.
// One transaction at a time; the next is accepted the cycle after the result
// register loads.
// Reset clears the table, held values and counter and sets the configuration registers to defaults.
// ---------------------------------------------------------------------------
`default_nettype none

`include "pulse_freq_duty_mode_filter_defines.svh"

module pulse_freq_duty_mode_filter
    import pfdm_pkg::*;
(
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic                 cfg_wen,
    input  wire logic [CFG_IDX_W-1:0] cfg_index,
    input  wire logic [15:0]          cfg_data,
    input  wire logic                 meas_valid,
    output logic                      meas_ready,
    input  wire meas_t                meas,
    output logic                      result_valid,
    input  wire logic                 result_ready,
    output result_t                   result
);

    pfdm_state_t state_reg, state_next;

    logic [15:0] freq_low_reg;
    logic [15:0] freq_high_reg;
    logic [6:0]  duty_low_reg;
    logic [6:0]  duty_high_reg;
    logic [15:0] clear_ivl_reg;

    logic [15:0] period_reg, period_next;
    logic [15:0] high_reg, high_next;
    logic        bad_reg, bad_next;
    logic        ok_reg, ok_next;
    logic [15:0] item_cnt_reg, item_cnt_next;
    logic [14:0] held_duty_reg, held_duty_next;
    logic [15:0] held_mode_reg, held_mode_next;
    logic [19:0] held_width_reg, held_width_next;
    result_t     result_reg, result_next;
    logic        result_valid_reg, result_valid_next;

    div_cmd_t    div_cmd;
    div_stat_t   div_stat;
    tbl_cmd_t    tbl_cmd;
    tbl_stat_t   tbl_stat;

    logic [15:0] in_period;
    logic [15:0] in_high;
    logic [31:0] duty_prod;
    logic [31:0] width_prod;
    logic [23:0] pct;
    logic [15:0] freq_sat;
    logic        freq_ok;

    pfdm_div u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .cmd   (div_cmd),
        .stat  (div_stat)
    );

    pfdm_table u_table (
        .clk   (clk),
        .rst_n (rst_n),
        .cmd   (tbl_cmd),
        .stat  (tbl_stat)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            freq_low_reg  <= 16'd100;
            freq_high_reg <= 16'd1000;
            duty_low_reg  <= 7'd10;
            duty_high_reg <= 7'd90;
            clear_ivl_reg <= 16'd4000;
        end
        else if (cfg_wen)
        begin
            unique case (cfg_index)
                REG_FREQ_LOW:       freq_low_reg  <= cfg_data;
                REG_FREQ_HIGH:      freq_high_reg <= cfg_data;
                REG_DUTY_LOW:       duty_low_reg  <= cfg_data[6:0];
                REG_DUTY_HIGH:      duty_high_reg <= cfg_data[6:0];
                REG_CLEAR_INTERVAL: clear_ivl_reg <= cfg_data;
                default:            ;
            endcase
        end
    end

    always_comb
    begin
        in_period  = meas.end_rise - meas.start_rise;
        in_high    = meas.fall_stamp - meas.start_rise;
        duty_prod  = 32'(high_reg) * 32'(DUTY_SCALE);
        width_prod = 32'(held_duty_reg) * 32'(WIDTH_SCALE);
        pct        = div_stat.quotient[DIV_W-1:8];
        freq_sat   = (|div_stat.quotient[DIV_W-1:16]) ? COUNT_MAX
                                                       : div_stat.quotient[15:0];
        freq_ok    = !bad_reg && (freq_sat != 16'd0) &&
                     (freq_sat >= freq_low_reg) && (freq_sat <= freq_high_reg);

        state_next        = state_reg;
        period_next       = period_reg;
        high_next         = high_reg;
        bad_next          = bad_reg;
        ok_next           = ok_reg;
        item_cnt_next     = item_cnt_reg;
        held_duty_next    = held_duty_reg;
        held_mode_next    = held_mode_reg;
        held_width_next   = held_width_reg;
        result_next       = result_reg;
        result_valid_next = result_valid_reg && !result_ready;
        meas_ready        = 1'b0;
        div_cmd           = '0;
        tbl_cmd           = '0;

        unique case (state_reg)
            ST_IDLE:
            begin
                meas_ready = 1'b1;
                if (meas_valid)
                begin
                    period_next = in_period;
                    high_next   = in_high;
                    bad_next    = (in_period < MIN_PERIOD);
                    ok_next     = 1'b0;
                    if (item_cnt_reg > clear_ivl_reg)
                    begin
                        tbl_cmd.clear = 1'b1;
                        item_cnt_next = 16'd1;
                    end
                    else if (item_cnt_reg != COUNT_MAX)
                    begin
                        item_cnt_next = item_cnt_reg + 16'd1;
                    end
                    state_next = ST_PREP;
                end
            end
            ST_PREP:
            begin
                if (period_reg == 16'd0)
                begin
                    state_next = ST_OUT;
                end
                else
                begin
                    div_cmd.start    = 1'b1;
                    div_cmd.dividend = duty_prod;
                    div_cmd.divisor  = period_reg;
                    state_next       = ST_DUTY;
                end
            end
            ST_DUTY:
            begin
                if (div_stat.done)
                begin
                    if ((pct > 24'(duty_low_reg)) && (pct < 24'(duty_high_reg)))
                    begin
                        held_duty_next = div_stat.quotient[14:0];
                    end
                    div_cmd.start    = 1'b1;
                    div_cmd.dividend = DIV_W'(TICK_HZ);
                    div_cmd.divisor  = period_reg;
                    state_next       = ST_FREQ;
                end
            end
            ST_FREQ:
            begin
                if (div_stat.done)
                begin
                    ok_next = freq_ok;
                    if (freq_ok)
                    begin
                        tbl_cmd.insert = 1'b1;
                        tbl_cmd.freq   = freq_sat;
                        state_next     = ST_TABLE;
                    end
                    else
                    begin
                        state_next = ST_OUT;
                    end
                end
            end
            ST_TABLE:
            begin
                if (tbl_stat.done)
                begin
                    held_mode_next = tbl_stat.mode_freq;
                    if (tbl_stat.mode_freq == 16'd0)
                    begin
                        held_width_next = '0;
                        state_next      = ST_OUT;
                    end
                    else
                    begin
                        div_cmd.start    = 1'b1;
                        div_cmd.dividend = {8'd0, width_prod[31:8]};
                        div_cmd.divisor  = tbl_stat.mode_freq;
                        state_next       = ST_WIDTH;
                    end
                end
            end
            ST_WIDTH:
            begin
                if (div_stat.done)
                begin
                    held_width_next = (div_stat.quotient > DIV_W'(WIDTH_MAX))
                                      ? WIDTH_MAX : div_stat.quotient[19:0];
                    state_next      = ST_OUT;
                end
            end
            ST_OUT:
            begin
                if (!result_valid_reg || result_ready)
                begin
                    result_next.mode_freq    = held_mode_reg;
                    result_next.duty_q8      = held_duty_reg;
                    result_next.high_time_us = held_width_reg;
                    result_next.in_range     = ok_reg;
                    result_next.bad_period   = bad_reg;
                    result_valid_next        = 1'b1;
                    state_next               = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= ST_IDLE;
            item_cnt_reg     <= '0;
            held_duty_reg    <= '0;
            held_mode_reg    <= '0;
            held_width_reg   <= '0;
            result_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg        <= state_next;
            item_cnt_reg     <= item_cnt_next;
            held_duty_reg    <= held_duty_next;
            held_mode_reg    <= held_mode_next;
            held_width_reg   <= held_width_next;
            result_valid_reg <= result_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        period_reg <= period_next;
        high_reg   <= high_next;
        bad_reg    <= bad_next;
        ok_reg     <= ok_next;
        result_reg <= result_next;
    end

    assign result_valid = result_valid_reg;
    assign result       = result_reg;

    `PFDM_ASSERT_IMP(a_tbl_done_in_table, tbl_stat.done, state_reg == ST_TABLE,
        "table done outside table wait")
    `PFDM_ASSERT_IMP(a_div_done_in_wait, div_stat.done,
        state_reg == ST_DUTY || state_reg == ST_FREQ || state_reg == ST_WIDTH,
        "divider done outside divide wait")
    `PFDM_ASSERT_NXT(a_accept_to_prep, meas_valid && meas_ready, state_reg == ST_PREP,
        "accepted transaction not started")
    `PFDM_ASSERT_IMP(a_zero_mode_width, held_mode_reg == 16'd0, held_width_reg == 20'd0,
        "nonzero width with zero mode")

endmodule

`default_nettype wire

// ===== rtl/pfdm_div.sv =====
// ---------------------------------------------------------------------------
// pfdm_div
// Shared restoring divider, one quotient bit per cycle, done pulse at end.
// ---------------------------------------------------------------------------
`default_nettype none

module pfdm_div
    import pfdm_pkg::*;
(
    input  wire logic     clk,
    input  wire logic     rst_n,
    input  wire div_cmd_t cmd,
    output div_stat_t     stat
);

    logic                 busy_reg, busy_next;
    logic                 done_reg, done_next;
    logic [DIV_CNT_W-1:0] cnt_reg, cnt_next;
    logic [DIVISOR_W-1:0] rem_reg, rem_next;
    logic [DIV_W-1:0]     quo_reg, quo_next;
    logic [DIVISOR_W-1:0] dvs_reg, dvs_next;

    logic [DIVISOR_W:0]   shifted;
    logic [DIVISOR_W:0]   trial;
    logic                 fits;

    always_comb
    begin
        shifted   = {rem_reg, quo_reg[DIV_W-1]};
        trial     = shifted - {1'b0, dvs_reg};
        fits      = (shifted >= {1'b0, dvs_reg});
        busy_next = busy_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        rem_next  = rem_reg;
        quo_next  = quo_reg;
        dvs_next  = dvs_reg;
        if (busy_reg)
        begin
            rem_next = fits ? trial[DIVISOR_W-1:0] : shifted[DIVISOR_W-1:0];
            quo_next = {quo_reg[DIV_W-2:0], fits};
            cnt_next = cnt_reg + DIV_CNT_W'(1);
            if (cnt_reg == DIV_CNT_W'(DIV_W - 1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
        else if (cmd.start)
        begin
            busy_next = 1'b1;
            cnt_next  = '0;
            rem_next  = '0;
            quo_next  = cmd.dividend;
            dvs_next  = cmd.divisor;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg <= rem_next;
        quo_reg <= quo_next;
        dvs_reg <= dvs_next;
    end

    assign stat.done     = done_reg;
    assign stat.quotient = quo_reg;

endmodule

`default_nettype wire

// ===== rtl/pfdm_table.sv =====
// ---------------------------------------------------------------------------
// pfdm_table
// Frequency/count slot table: match-or-fill scan, eviction, then mode scan.
// ---------------------------------------------------------------------------
`default_nettype none

module pfdm_table
    import pfdm_pkg::*;
(
    input  wire logic     clk,
    input  wire logic     rst_n,
    input  wire tbl_cmd_t cmd,
    output tbl_stat_t     stat
);

    tbl_state_t            state_reg, state_next;
    logic [SLOT_IDX_W-1:0] idx_reg, idx_next;
    logic [SLOT_IDX_W-1:0] vic_reg, vic_next;
    logic [15:0]           key_reg, key_next;
    logic [15:0]           min_reg, min_next;
    logic [15:0]           top_reg, top_next;
    logic [15:0]           best_reg, best_next;
    logic [15:0]           slot_freq_reg  [TABLE_SLOTS];
    logic [15:0]           slot_count_reg [TABLE_SLOTS];

    logic [15:0]           cur_f;
    logic [15:0]           cur_c;
    logic                  last;
    logic                  take;
    logic                  wr_en;
    logic [15:0]           wr_freq;
    logic [15:0]           wr_count;
    logic                  clr_all;

    always_comb
    begin
        cur_f      = slot_freq_reg[idx_reg];
        cur_c      = slot_count_reg[idx_reg];
        last       = (idx_reg == SLOT_IDX_W'(TABLE_SLOTS - 1));
        take       = 1'b0;
        state_next = state_reg;
        idx_next   = idx_reg;
        vic_next   = vic_reg;
        key_next   = key_reg;
        min_next   = min_reg;
        top_next   = top_reg;
        best_next  = best_reg;
        wr_en      = 1'b0;
        wr_freq    = key_reg;
        wr_count   = '0;
        clr_all    = 1'b0;
        unique case (state_reg)
            TB_IDLE:
            begin
                clr_all = cmd.clear;
                if (cmd.insert)
                begin
                    key_next   = cmd.freq;
                    idx_next   = '0;
                    state_next = TB_FIND;
                end
            end
            TB_FIND:
            begin
                if (cur_f == key_reg)
                begin
                    wr_en      = 1'b1;
                    wr_freq    = cur_f;
                    wr_count   = (cur_c == COUNT_MAX) ? cur_c : cur_c + 16'd1;
                    idx_next   = '0;
                    state_next = TB_MODE;
                end
                else if (cur_f == 16'd0)
                begin
                    wr_en      = 1'b1;
                    idx_next   = '0;
                    state_next = TB_MODE;
                end
                else
                begin
                    take = (idx_reg == '0) || (cur_c < min_reg);
                    if (take)
                    begin
                        min_next = cur_c;
                        vic_next = idx_reg;
                    end
                    if (last)
                    begin
                        idx_next   = take ? idx_reg : vic_reg;
                        state_next = TB_EVICT;
                    end
                    else
                    begin
                        idx_next = idx_reg + SLOT_IDX_W'(1);
                    end
                end
            end
            TB_EVICT:
            begin
                wr_en      = 1'b1;
                idx_next   = '0;
                state_next = TB_MODE;
            end
            TB_MODE:
            begin
                if ((idx_reg == '0) || (cur_c > top_reg))
                begin
                    top_next  = cur_c;
                    best_next = cur_f;
                end
                if (last)
                begin
                    state_next = TB_DONE;
                end
                else
                begin
                    idx_next = idx_reg + SLOT_IDX_W'(1);
                end
            end
            TB_DONE:
            begin
                state_next = TB_IDLE;
            end
            default:
            begin
                state_next = TB_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= TB_IDLE;
            for (int i = 0; i < TABLE_SLOTS; i++)
            begin
                slot_freq_reg[i]  <= '0;
                slot_count_reg[i] <= '0;
            end
        end
        else
        begin
            state_reg <= state_next;
            for (int i = 0; i < TABLE_SLOTS; i++)
            begin
                if (clr_all)
                begin
                    slot_count_reg[i] <= '0;
                end
                else if (wr_en && (idx_reg == SLOT_IDX_W'(i)))
                begin
                    slot_freq_reg[i]  <= wr_freq;
                    slot_count_reg[i] <= wr_count;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        idx_reg  <= idx_next;
        vic_reg  <= vic_next;
        key_reg  <= key_next;
        min_reg  <= min_next;
        top_reg  <= top_next;
        best_reg <= best_next;
    end

    assign stat.done      = (state_reg == TB_DONE);
    assign stat.mode_freq = best_reg;

endmodule

`default_nettype wire
